// ===== sv/ppm_ctx_pkg.sv =====
// Shared types and constants for the context symbol table.
package ppm_ctx_pkg;

  localparam int SYM_W   = 8;
  localparam int CNT_W   = 16;
  localparam int TOTAL_W = 9;

  typedef enum logic [1:0] {
    OP_OBSERVE = 2'd0,
    OP_FORGET  = 2'd1,
    OP_FIND    = 2'd2,
    OP_CLEAR   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    CELL_NOP = 3'd0,
    CELL_INC = 3'd1,
    CELL_DEC = 3'd2,
    CELL_INS = 3'd3,
    CELL_DEL = 3'd4,
    CELL_CLR = 3'd5
  } cell_cmd_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    cell_cmd_t                 cmd;
    logic signed [SYM_W-1:0]   key;
  } cell_op_t;

  // Contents of one cell as seen by its neighbours.
  typedef struct packed {
    logic                      valid;
    logic                      less;
    logic signed [SYM_W-1:0]   sym;
    logic [CNT_W-1:0]          count;
  } cell_t;

endpackage

// ===== sv/ppm_ctx_cell.sv =====
// One entry of the sorted symbol row: compare, count and shift to either side.
module ppm_ctx_cell #(
  parameter int COUNT_MAX = 65535
) (
  input  logic               clk,
  input  logic               rst,
  input  ppm_ctx_pkg::cell_op_t op,
  input  ppm_ctx_pkg::cell_t left,
  input  ppm_ctx_pkg::cell_t right,
  output ppm_ctx_pkg::cell_t self,
  output logic               match
);
  import ppm_ctx_pkg::*;

  logic                    valid;
  logic signed [SYM_W-1:0] sym;
  logic [CNT_W-1:0]        count;
  logic                    less;

  assign match = valid && (sym == op.key);
  assign less  = valid && (sym < op.key);

  assign self = '{valid: valid, less: less, sym: sym, count: count};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      unique case (op.cmd)
        CELL_INS: begin
          // cells at or above the insertion point move up by one
          if (!less) begin
            valid <= left.less ? 1'b1 : left.valid;
          end
        end
        CELL_DEL: begin
          if (!less) begin
            valid <= right.valid;
          end
        end
        CELL_CLR: valid <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (op.cmd)
      CELL_INC: begin
        if (match && (count < CNT_W'(COUNT_MAX))) begin
          count <= count + 1'b1;
        end
      end
      CELL_DEC: begin
        if (match) begin
          count <= count - 1'b1;
        end
      end
      CELL_INS: begin
        if (!less) begin
          if (left.less) begin
            sym   <= op.key;
            count <= CNT_W'(1);
          end else begin
            sym   <= left.sym;
            count <= left.count;
          end
        end
      end
      CELL_DEL: begin
        if (!less) begin
          sym   <= right.sym;
          count <= right.count;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/ppm_ctx_or_tree.sv =====
// Registered reduction of the one-hot cell matches and the matching count.
module ppm_ctx_or_tree #(
  parameter int N = 256
) (
  input  logic                                clk,
  input  logic [N-1:0]                        hit,
  input  logic [N-1:0][ppm_ctx_pkg::CNT_W-1:0] counts,
  output logic                                any_hit,
  output logic [ppm_ctx_pkg::CNT_W-1:0]       hit_count
);
  import ppm_ctx_pkg::*;

  logic [CNT_W-1:0] masked_or;

  always_comb begin
    masked_or = '0;
    for (int i = 0; i < N; i++) begin
      masked_or = masked_or | (counts[i] & {CNT_W{hit[i]}});
    end
  end

  always_ff @(posedge clk) begin
    any_hit   <= |hit;
    hit_count <= masked_or;
  end

endmodule

// ===== sv/ppm_context_symbol_table.sv =====
// Context symbol table: a sorted row of symbol/count cells with escape handling.
// Each input word is handled alone: the symbol is looked up across the cell row,
// the match is reduced through one registered stage, then the row is told to
// count, insert or remove, cells from that place on shifting by one together. Find,
// clear and an observe or forget that needs no escape update pass through lookup,
// decision and completion, and no new word is taken until the table is idle again.
// An escape update adds a second lookup and action: a new symbol then passes
// through escape lookup, escape action and symbol insert, and a removal with
// escape forget through escape lookup and escape action. The next word is taken
// as soon as the previous result sits in the output register, even if it is not
// yet taken. A result still waiting there holds the following one in its last
// step until it is taken.
module ppm_context_symbol_table #(
  parameter int TABLE_DEPTH = 256,
  parameter int COUNT_MAX   = 65535
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,      // escape_symbol
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // opcode[1:0], symbol[9:2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // found[0], symbol_count[16:1],
                                      // entry_total[25:17], saturated[26]
);
  import ppm_ctx_pkg::*;

  localparam int NUM_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_PSYM   = 7'b0000010,
    ST_DECIDE = 7'b0000100,
    ST_PESC   = 7'b0001000,
    ST_EACT   = 7'b0010000,
    ST_SINS   = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  localparam cell_t HEAD_CELL = '{valid: 1'b1, less: 1'b1, sym: '0, count: '0};
  localparam cell_t TAIL_CELL = '{valid: 1'b0, less: 1'b0, sym: '0, count: '0};

  state_t                  state, state_next;
  logic signed [SYM_W-1:0] esc;
  opcode_t                 op_q;
  logic signed [SYM_W-1:0] sym_q;
  logic [NUM_W-1:0]        number, number_next;
  logic                    was, was_next;
  logic                    sat, sat_next;
  logic [CNT_W-1:0]        res_count, res_count_next;
  logic                    full;

  cell_op_t                cell_op;
  cell_t                   cells [TABLE_DEPTH];
  cell_t                   left_in [TABLE_DEPTH];
  cell_t                   right_in [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]  cell_hit;
  logic [TABLE_DEPTH-1:0]  cell_valid;
  logic [TABLE_DEPTH-1:0][CNT_W-1:0] cell_count;
  logic                    red_hit;
  logic [CNT_W-1:0]        red_count;

  logic                    out_valid;
  logic                    out_found;
  logic [CNT_W-1:0]        out_count;
  logic [TOTAL_W-1:0]      out_total;
  logic                    out_sat;

  // cell row
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_row
    if (i == 0) begin : g_first
      assign left_in[i] = HEAD_CELL;
    end else begin : g_mid_l
      assign left_in[i] = cells[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign right_in[i] = TAIL_CELL;
    end else begin : g_mid_r
      assign right_in[i] = cells[i+1];
    end

    ppm_ctx_cell #(.COUNT_MAX(COUNT_MAX)) u_cell (
      .clk   (clk),
      .rst   (rst),
      .op    (cell_op),
      .left  (left_in[i]),
      .right (right_in[i]),
      .self  (cells[i]),
      .match (cell_hit[i])
    );

    assign cell_valid[i] = cells[i].valid;
    assign cell_count[i] = cells[i].count;
  end

  ppm_ctx_or_tree #(.N(TABLE_DEPTH)) u_reduce (
    .clk       (clk),
    .hit       (cell_hit),
    .counts    (cell_count),
    .any_hit   (red_hit),
    .hit_count (red_count)
  );

  assign full          = (number == NUM_W'(TABLE_DEPTH));
  assign s_axis_tready = (state == ST_IDLE);

  always_comb begin
    state_next     = state;
    number_next    = number;
    was_next       = was;
    sat_next       = sat;
    res_count_next = res_count;
    cell_op.cmd    = CELL_NOP;
    cell_op.key    = ((state == ST_PESC) || (state == ST_EACT)) ? esc : sym_q;

    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          sat_next   = 1'b0;
          state_next = ST_PSYM;
        end
      end
      ST_PSYM: state_next = ST_DECIDE;
      ST_DECIDE: begin
        was_next   = red_hit;
        state_next = ST_DONE;
        unique case (op_q)
          OP_FIND: res_count_next = red_count;
          OP_CLEAR: begin
            cell_op.cmd    = CELL_CLR;
            number_next    = '0;
            res_count_next = '0;
          end
          OP_OBSERVE: begin
            if (red_hit) begin
              cell_op.cmd = CELL_INC;
              if (red_count >= CNT_W'(COUNT_MAX)) begin
                sat_next       = 1'b1;
                res_count_next = red_count;
              end else begin
                res_count_next = red_count + 1'b1;
              end
            end else if (sym_q != esc) begin
              state_next = ST_PESC;
            end else if (!full) begin
              cell_op.cmd    = CELL_INS;
              number_next    = number + 1'b1;
              res_count_next = CNT_W'(1);
            end else begin
              res_count_next = '0;
            end
          end
          OP_FORGET: begin
            if (!red_hit) begin
              res_count_next = '0;
            end else if (red_count > CNT_W'(1)) begin
              cell_op.cmd    = CELL_DEC;
              res_count_next = red_count - 1'b1;
            end else begin
              cell_op.cmd    = CELL_DEL;
              number_next    = number - 1'b1;
              res_count_next = '0;
              if (sym_q != esc) begin
                state_next = ST_PESC;
              end
            end
          end
          default: ;
        endcase
      end
      ST_PESC: state_next = ST_EACT;
      ST_EACT: begin
        // escape lookup is in the reduction register now
        if (op_q == OP_OBSERVE) begin
          state_next = ST_SINS;
          if (red_hit) begin
            cell_op.cmd = CELL_INC;
            if (red_count >= CNT_W'(COUNT_MAX)) begin
              sat_next = 1'b1;
            end
          end else if (!full) begin
            cell_op.cmd = CELL_INS;
            number_next = number + 1'b1;
          end
        end else begin
          state_next = ST_DONE;
          if (red_hit) begin
            if (red_count > CNT_W'(1)) begin
              cell_op.cmd = CELL_DEC;
            end else begin
              cell_op.cmd = CELL_DEL;
              number_next = number - 1'b1;
            end
          end
        end
      end
      ST_SINS: begin
        state_next = ST_DONE;
        if (!full) begin
          cell_op.cmd    = CELL_INS;
          number_next    = number + 1'b1;
          res_count_next = CNT_W'(1);
        end else begin
          res_count_next = '0;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid || m_axis_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      number    <= '0;
      esc       <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      number <= number_next;
      if (cfg_we) begin
        esc <= cfg_wdata;
      end
      if ((state == ST_DONE) && (!out_valid || m_axis_tready)) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    was       <= was_next;
    sat       <= sat_next;
    res_count <= res_count_next;
    if (s_axis_tvalid && s_axis_tready) begin
      op_q  <= opcode_t'(s_axis_tdata[1:0]);
      sym_q <= s_axis_tdata[9:2];
    end
    if ((state == ST_DONE) && (!out_valid || m_axis_tready)) begin
      out_found <= was;
      out_count <= res_count;
      out_total <= TOTAL_W'(number);
      out_sat   <= sat;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_sat, out_total, out_count, out_found};

  // Occupied cells form a prefix of the row and match the entry count.
  a_count_matches_cells: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> ($countones(cell_valid) == int'(number)))
    else $error("cell occupancy differs from entry count");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    int'(number) <= TABLE_DEPTH)
    else $error("entry count beyond table depth");

  a_result_after_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == ST_DONE))
    else $error("result raised outside completion");

endmodule
